>>> design/grid_line_of_sight_unit_assert.svh
// ----------------------------------------------------------------------------
// grid line of sight assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_UNIT_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define GLOS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define GLOS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define GLOS_ASSERT(lbl, clk, rstn, prop)
`define GLOS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> design/glos_pkg.sv
// ----------------------------------------------------------------------------
// grid line of sight package
// shared constants and parameter defaults
// ----------------------------------------------------------------------------
package glos_pkg;

  localparam int unsigned MAP_SIZE_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned POS_BITS      = 14;
  localparam int unsigned CELL_BITS     = 6;

endpackage

>>> design/glos_ram.sv
// ----------------------------------------------------------------------------
// grid line of sight ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module glos_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/grid_line_of_sight_unit.sv
// ----------------------------------------------------------------------------
// grid line of sight unit
// wall map of MAP_SIZE x MAP_SIZE cells with line-of-sight queries walked
// cell by cell by grid traversal between two fixed-point positions
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge with start_i high and busy_o low.
// req_type_i low writes cell_wall_i into map cell (cell_x_i, cell_y_i); the
// write gives no result and busy_o stays low. req_type_i high starts a
// query from observer to target; busy_o then stays high until the answer is
// shown on visible_o and walk_aborted_o, marked by done_o high for one
// cycle. The result cannot be held off; it is taken at the edge ending that
// cycle, and a new request may be taken at that same edge.
// A query tests at most 2 * MAP_SIZE + 1 cells. The setup states ST_MUL1
// and ST_MUL2 share one multiplier for the cross products and ST_SUB forms
// the initial difference; after that the walk issues one map read per cycle
// through the single read port, and the wall test of a cell comes in the
// cycle after its read.
// Reset: the map is swept to open, one cell per cycle, over all MAP_SIZE *
// MAP_SIZE cells (4096 at the defaults) with busy_o high.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_unit_assert.svh"

module grid_line_of_sight_unit #(
  parameter int unsigned MAP_SIZE  = glos_pkg::MAP_SIZE_DEF,
  parameter int unsigned FRAC_BITS = glos_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [glos_pkg::CELL_BITS-1:0]  cell_x_i,
  input  logic [glos_pkg::CELL_BITS-1:0]  cell_y_i,
  input  logic                            cell_wall_i,
  input  logic [glos_pkg::POS_BITS-1:0]   observer_x_i,
  input  logic [glos_pkg::POS_BITS-1:0]   observer_y_i,
  input  logic [glos_pkg::POS_BITS-1:0]   target_x_i,
  input  logic [glos_pkg::POS_BITS-1:0]   target_y_i,
  output logic                            done_o,
  output logic                            visible_o,
  output logic                            walk_aborted_o
);

  import glos_pkg::*;

  localparam int unsigned DEPTH      = MAP_SIZE * MAP_SIZE;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned MW         = $clog2(MAP_SIZE);
  localparam int unsigned CIW        = POS_BITS - FRAC_BITS;
  localparam int unsigned CW         = ((CIW > MW) ? CIW : MW) + 2;
  localparam int unsigned FW         = FRAC_BITS + 1;
  localparam int unsigned PW         = FW + POS_BITS;
  localparam int unsigned STEP_LIMIT = 2 * MAP_SIZE;
  localparam int unsigned SLW        = $clog2(STEP_LIMIT + 2);
  localparam int unsigned DW         = FRAC_BITS + POS_BITS + SLW + 3;

  localparam logic [AW-1:0]        MAP_SIZE_A = AW'(MAP_SIZE);
  localparam logic [AW-1:0]        LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic signed [CW-1:0] MAP_LIM    = CW'(MAP_SIZE);
  localparam logic [FW-1:0]        ONE_F      = FW'(1) << FRAC_BITS;
  localparam logic [SLW-1:0]       LIMIT_S    = SLW'(STEP_LIMIT);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_SUB   = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic signed [CW-1:0]    cx_q, cx_d, cy_q, cy_d, gx_q, gx_d, gy_q, gy_d;
  logic                    sxn_q, sxn_d, syn_q, syn_d;
  logic [POS_BITS-1:0]     adx_q, adx_d, ady_q, ady_d;
  logic [FW-1:0]           fx_q, fx_d, fy_q, fy_d;
  logic [PW-1:0]           prod_q, prod_d;
  logic signed [DW-1:0]    diff_q, diff_d;
  logic [SLW-1:0]          steps_q, steps_d;
  logic                    chk_vld_q, chk_vld_d, chk_in_q, chk_in_d;
  logic                    chk_tgt_q, chk_tgt_d, chk_lim_q, chk_lim_d;
  logic                    done_q, done_d, vis_q, vis_d, abt_q, abt_d;

  logic                    accept;
  logic                    obs_xn, obs_yn;
  logic [FW-1:0]           mul_a;
  logic [POS_BITS-1:0]     mul_b;
  logic [PW-1:0]           mul_p;
  logic                    step_x, add_sub;
  logic signed [DW-1:0]    inc_x, inc_y, add_b, add_r;
  logic                    cur_in, cur_tgt, cur_lim, wr_in, fin;
  logic signed [CW-1:0]    step_sx, step_sy;
  logic                    ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]           ram_waddr, ram_raddr;

  assign accept = start_i && (state_q == ST_IDLE);
  assign obs_xn = observer_x_i > target_x_i;
  assign obs_yn = observer_y_i > target_y_i;

  // shared multiplier for the two cross products
  assign mul_a = (state_q == ST_MUL1) ? fx_q : fy_q;
  assign mul_b = (state_q == ST_MUL1) ? ady_q : adx_q;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // shared adder: initial difference, then one boundary step per cycle
  assign step_x  = (adx_q != '0) && diff_q[DW-1];
  assign inc_x   = DW'(ady_q) << FRAC_BITS;
  assign inc_y   = DW'(adx_q) << FRAC_BITS;
  assign add_sub = (state_q == ST_SUB) || !step_x;
  assign add_b   = (state_q == ST_SUB) ? DW'(prod_q) : (step_x ? inc_x : inc_y);
  assign add_r   = add_sub ? (diff_q - add_b) : (diff_q + add_b);

  assign step_sx = sxn_q ? '1 : CW'(1);
  assign step_sy = syn_q ? '1 : CW'(1);

  // current walk cell
  assign cur_in  = !cx_q[CW-1] && !cy_q[CW-1] && (cx_q < MAP_LIM) && (cy_q < MAP_LIM);
  assign cur_tgt = (cx_q == gx_q) && (cy_q == gy_q);
  assign cur_lim = steps_q >= LIMIT_S;
  assign ram_raddr = cur_in ? AW'(AW'(cy_q[MW-1:0]) * MAP_SIZE_A + AW'(cx_q[MW-1:0]))
                            : '0;

  assign wr_in = (32'(cell_x_i) < MAP_SIZE) && (32'(cell_y_i) < MAP_SIZE);
  assign ram_we = (state_q == ST_CLEAR) || (accept && !req_type_i && wr_in);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q
                     : AW'(AW'(cell_y_i) * MAP_SIZE_A + AW'(cell_x_i));
  assign ram_wdata = (state_q == ST_CLEAR) ? 1'b0 : cell_wall_i;

  assign fin = chk_vld_q && (!chk_in_q || ram_rdata || chk_tgt_q || chk_lim_q);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    gx_d      = gx_q;
    gy_d      = gy_q;
    sxn_d     = sxn_q;
    syn_d     = syn_q;
    adx_d     = adx_q;
    ady_d     = ady_q;
    fx_d      = fx_q;
    fy_d      = fy_q;
    prod_d    = prod_q;
    diff_d    = diff_q;
    steps_d   = steps_q;
    chk_vld_d = chk_vld_q;
    chk_in_d  = chk_in_q;
    chk_tgt_d = chk_tgt_q;
    chk_lim_d = chk_lim_q;
    done_d    = 1'b0;
    vis_d     = vis_q;
    abt_d     = abt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && req_type_i) begin
          cx_d  = CW'(observer_x_i >> FRAC_BITS);
          cy_d  = CW'(observer_y_i >> FRAC_BITS);
          gx_d  = CW'(target_x_i >> FRAC_BITS);
          gy_d  = CW'(target_y_i >> FRAC_BITS);
          sxn_d = obs_xn;
          syn_d = obs_yn;
          adx_d = obs_xn ? (observer_x_i - target_x_i) : (target_x_i - observer_x_i);
          ady_d = obs_yn ? (observer_y_i - target_y_i) : (target_y_i - observer_y_i);
          fx_d  = obs_xn ? FW'(observer_x_i[FRAC_BITS-1:0])
                         : ONE_F - FW'(observer_x_i[FRAC_BITS-1:0]);
          fy_d  = obs_yn ? FW'(observer_y_i[FRAC_BITS-1:0])
                         : ONE_F - FW'(observer_y_i[FRAC_BITS-1:0]);
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_d  = mul_p;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        diff_d  = DW'(prod_q);
        prod_d  = mul_p;
        state_d = ST_SUB;
      end
      ST_SUB: begin
        diff_d    = add_r;
        steps_d   = '0;
        chk_vld_d = 1'b0;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        // issue the read of the current cell and move one cell on
        chk_vld_d = 1'b1;
        chk_in_d  = cur_in;
        chk_tgt_d = cur_tgt;
        chk_lim_d = cur_lim;
        steps_d   = steps_q + SLW'(1);
        diff_d    = add_r;
        if (step_x) begin
          cx_d = cx_q + step_sx;
        end else begin
          cy_d = cy_q + step_sy;
        end
        // test the cell read in the previous cycle
        if (fin) begin
          done_d    = 1'b1;
          chk_vld_d = 1'b0;
          state_d   = ST_IDLE;
          priority if (!chk_in_q) begin
            vis_d = 1'b0;
            abt_d = 1'b1;
          end else if (ram_rdata) begin
            vis_d = 1'b0;
            abt_d = 1'b0;
          end else if (chk_tgt_q) begin
            vis_d = 1'b1;
            abt_d = 1'b0;
          end else begin
            vis_d = 1'b0;
            abt_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      steps_q   <= '0;
      chk_vld_q <= 1'b0;
      done_q    <= 1'b0;
      vis_q     <= 1'b0;
      abt_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      steps_q   <= steps_d;
      chk_vld_q <= chk_vld_d;
      done_q    <= done_d;
      vis_q     <= vis_d;
      abt_q     <= abt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    gx_q      <= gx_d;
    gy_q      <= gy_d;
    sxn_q     <= sxn_d;
    syn_q     <= syn_d;
    adx_q     <= adx_d;
    ady_q     <= ady_d;
    fx_q      <= fx_d;
    fy_q      <= fy_d;
    prod_q    <= prod_d;
    diff_q    <= diff_d;
    chk_in_q  <= chk_in_d;
    chk_tgt_q <= chk_tgt_d;
    chk_lim_q <= chk_lim_d;
  end

  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign visible_o      = vis_q;
  assign walk_aborted_o = abt_q;

  `GLOS_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o)
  `GLOS_ASSERT_NEVER(a_vis_abort, clk_i, rst_ni, done_o && visible_o && walk_aborted_o)
  `GLOS_ASSERT(a_query_busy, clk_i, rst_ni, start_i && !busy_o && req_type_i |=> busy_o)
  `GLOS_ASSERT(a_write_quiet, clk_i, rst_ni, start_i && !busy_o && !req_type_i |=> !busy_o && !done_o)
  `GLOS_ASSERT(a_steps_bound, clk_i, rst_ni, steps_q <= SLW'(STEP_LIMIT + 2))

endmodule
